FILE: hdl/cls_pkg.sv
`default_nettype none

package cls_pkg;

	localparam int MAX_LINE = 4096;
	localparam int CFG_W    = 13;
	localparam int POS_W    = 12;
	localparam int BYTE_W   = 8;

	typedef logic [POS_W-1:0]  count_t;
	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [CFG_W-1:0]  cfg_t;

	// Largest usable buffer size: the build limit, capped by what the position field holds.
	localparam int LIMIT_CAP = (MAX_LINE < (2 ** POS_W)) ? MAX_LINE : (2 ** POS_W);

	localparam cfg_t CFG_RESET = cfg_t'(4096);

	localparam byte_t CH_NUL   = 8'h00;
	localparam byte_t CH_TAB   = 8'h09;
	localparam byte_t CH_LF    = 8'h0A;
	localparam byte_t CH_CR    = 8'h0D;
	localparam byte_t CH_SP    = 8'h20;
	localparam byte_t CH_QUOTE = 8'h22;
	localparam byte_t CH_SEMI  = 8'h3B;
	localparam byte_t CH_BSL   = 8'h5C;

	localparam logic KIND_CHAR = 1'b0;
	localparam logic KIND_EOL  = 1'b1;

	typedef struct packed {
		logic   kind;
		byte_t  char_out;
		count_t position;
		count_t line_length;
		logic   last;
	} res_t;

	// Results produced by one item: count, then up to two results in order.
	typedef struct packed {
		logic [1:0] num;
		res_t       first;
		res_t       second;
	} push_t;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Number of bytes a line may hold before it is cut.
	function automatic count_t calc_limit(cfg_t size);
		cfg_t sz;
		sz = size;
		if (sz > cfg_t'(LIMIT_CAP)) sz = cfg_t'(LIMIT_CAP);
		if (sz < cfg_t'(2)) sz = cfg_t'(2);
		return count_t'(sz - cfg_t'(1));
	endfunction

	localparam count_t LIMIT_RESET = calc_limit(CFG_RESET);

endpackage

`default_nettype wire

FILE: hdl/cls_if.sv
`default_nettype none

interface cls_text_if;
	logic           valid;
	logic           ready;
	cls_pkg::byte_t byte_in;
	logic           end_of_input;

	modport source(output valid, byte_in, end_of_input, input ready);
	modport sink(input valid, byte_in, end_of_input, output ready);
endinterface

interface cls_result_if;
	logic            valid;
	logic            ready;
	logic            kind;
	cls_pkg::byte_t  char_out;
	cls_pkg::count_t position;
	cls_pkg::count_t line_length;
	logic            last;

	modport source(output valid, kind, char_out, position, line_length, last, input ready);
	modport sink(input valid, kind, char_out, position, line_length, last, output ready);
endinterface

interface cls_cfg_if;
	logic           valid;
	logic           ready;
	cls_pkg::cfg_t  line_size;

	modport source(output valid, line_size, input ready);
	modport sink(input valid, line_size, output ready);
endinterface

`default_nettype wire

FILE: hdl/config_line_splitter_top.sv
// Configuration line splitter. Takes one text byte per item on the text channel and produces
// results on the result channel: each kept character with its position in the line, and an
// end-of-line result carrying the line length with trailing blanks stripped. One item is
// accepted every cycle while the result queue has room; each item yields zero, one or two
// results, and the result channel delivers one result per cycle while its sink is ready, so
// a run of items that each end a full line is held back to the pace of the result channel.
// An item passes an input register, is decoded from it and is written into a four-entry
// result queue, from which its first result is offered. The line_size register may be
// written whenever the block is idle; lines are cut after line_size minus one bytes, with
// sizes above 4096 treated as 4096 and sizes below 2 treated as 2. The line state survives
// idle periods until a line end or an end-of-input item closes it.
`default_nettype none

module config_line_splitter_top (
	input  wire logic    clk,
	input  wire logic    arst_n,
	cls_text_if.sink     text,
	cls_cfg_if.sink      cfg,
	cls_result_if.source result
);

	cls_pkg::push_t push;
	logic           room;

	cls_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text),
		.cfg    (cfg),
		.room   (room),
		.push   (push)
	);

	cls_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room   (room),
		.result (result)
	);

endmodule

`default_nettype wire

FILE: hdl/cls_core.sv
`default_nettype none

module cls_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	cls_text_if.sink         text,
	cls_cfg_if.sink          cfg,
	input  wire logic        room,
	output cls_pkg::push_t   push
);

	logic            valid_s1;
	cls_pkg::byte_t  byte_s1;
	logic            eoi_s1;

	logic            in_quote_q, escaped_q;
	cls_pkg::count_t kept_q, trimmed_q;
	cls_pkg::count_t limit_q;

	logic            in_quote_n, escaped_n;
	cls_pkg::count_t kept_n, trimmed_n;
	cls_pkg::count_t kept_inc, trim_new;
	logic            is_ws;
	logic            fire;
	logic [1:0]      num;
	cls_pkg::res_t   first, second;

	assign fire       = valid_s1 && room;
	assign text.ready = !valid_s1 || room;
	assign cfg.ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.ready) begin
			valid_s1 <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text.valid && text.ready) begin
			byte_s1 <= text.byte_in;
			eoi_s1  <= text.end_of_input;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= cls_pkg::LIMIT_RESET;
		end else if (cfg.valid) begin
			limit_q <= cls_pkg::calc_limit(cfg.line_size);
		end
	end

	always_comb begin
		kept_inc   = kept_q + cls_pkg::count_t'(1);
		is_ws      = (byte_s1 == cls_pkg::CH_SP) || (byte_s1 == cls_pkg::CH_TAB);
		trim_new   = is_ws ? trimmed_q : kept_inc;
		in_quote_n = in_quote_q;
		escaped_n  = escaped_q;
		kept_n     = kept_q;
		trimmed_n  = trimmed_q;
		num        = 2'd0;

		first.kind        = cls_pkg::KIND_EOL;
		first.char_out    = '0;
		first.position    = '0;
		first.line_length = trimmed_q;
		first.last        = 1'b1;

		second.kind        = cls_pkg::KIND_EOL;
		second.char_out    = '0;
		second.position    = '0;
		second.line_length = trim_new;
		second.last        = 1'b1;

		if (eoi_s1) begin
			if (kept_q != '0) num = 2'd1;
			in_quote_n = 1'b0;
			escaped_n  = 1'b0;
			kept_n     = '0;
			trimmed_n  = '0;
		end else if ((byte_s1 == cls_pkg::CH_NUL) || (byte_s1 == cls_pkg::CH_LF) ||
				((byte_s1 == cls_pkg::CH_SEMI) && !escaped_q && !in_quote_q)) begin
			// An empty line leaves quote and escape state as it was.
			if (kept_q != '0) begin
				num        = 2'd1;
				in_quote_n = 1'b0;
				escaped_n  = 1'b0;
				kept_n     = '0;
				trimmed_n  = '0;
			end
		end else if (byte_s1 == cls_pkg::CH_CR) begin
			num = 2'd0;
		end else if ((byte_s1 == cls_pkg::CH_BSL) && !escaped_q) begin
			escaped_n = 1'b1;
		end else if ((byte_s1 == cls_pkg::CH_QUOTE) && !escaped_q) begin
			in_quote_n = !in_quote_q;
		end else if (is_ws && (kept_q == '0)) begin
			num = 2'd0;
		end else begin
			first.kind        = cls_pkg::KIND_CHAR;
			first.char_out    = byte_s1;
			first.position    = kept_q;
			first.line_length = '0;
			if (kept_inc >= limit_q) begin
				// Line is full: the character is followed by its line end.
				num        = 2'd2;
				first.last = 1'b0;
				in_quote_n = 1'b0;
				escaped_n  = 1'b0;
				kept_n     = '0;
				trimmed_n  = '0;
			end else begin
				num       = 2'd1;
				kept_n    = kept_inc;
				trimmed_n = trim_new;
				escaped_n = 1'b0;
			end
		end
	end

	assign push.num    = fire ? num : 2'd0;
	assign push.first  = first;
	assign push.second = second;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_quote_q <= 1'b0;
			escaped_q  <= 1'b0;
			kept_q     <= '0;
			trimmed_q  <= '0;
		end else if (fire) begin
			in_quote_q <= in_quote_n;
			escaped_q  <= escaped_n;
			kept_q     <= kept_n;
			trimmed_q  <= trimmed_n;
		end
	end

	a_eoi_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && eoi_s1 |=> (kept_q == '0) && (trimmed_q == '0) && !in_quote_q && !escaped_q)
		else $error("end of input did not clear the line state");

	a_trim_bound: assert property (@(posedge clk) disable iff (!arst_n)
		trimmed_q <= kept_q)
		else $error("trimmed length exceeds kept length");

	a_no_push_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |-> (push.num == 2'd0))
		else $error("results pushed without a processed item");

endmodule

`default_nettype wire

FILE: hdl/cls_outq.sv
`default_nettype none

module cls_outq (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire cls_pkg::push_t push,
	output logic                room,
	cls_result_if.source        result
);

	cls_pkg::res_t                entries_q [cls_pkg::QDEPTH];
	logic [cls_pkg::QPTR_W-1:0]   wr_ptr_q, rd_ptr_q, wr_ptr_p1;
	logic [cls_pkg::QCNT_W-1:0]   count_q;
	logic                         pop;
	cls_pkg::res_t                head;

	// Two free slots are needed, since one item can produce two results.
	assign room      = count_q <= cls_pkg::QCNT_W'(cls_pkg::QDEPTH - 2);
	assign pop       = result.valid && result.ready;
	assign wr_ptr_p1 = wr_ptr_q + cls_pkg::QPTR_W'(1);
	assign head      = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push.num != 2'd0) entries_q[wr_ptr_q] <= push.first;
		if (push.num == 2'd2) entries_q[wr_ptr_p1] <= push.second;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + cls_pkg::QPTR_W'(push.num);
			if (pop) rd_ptr_q <= rd_ptr_q + cls_pkg::QPTR_W'(1);
			count_q <= count_q + cls_pkg::QCNT_W'(push.num) - cls_pkg::QCNT_W'(pop);
		end
	end

	assign result.valid       = count_q != '0;
	assign result.kind        = head.kind;
	assign result.char_out    = head.char_out;
	assign result.position    = head.position;
	assign result.line_length = head.line_length;
	assign result.last        = head.last;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= cls_pkg::QCNT_W'(cls_pkg::QDEPTH))
		else $error("result queue count out of range");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push.num != 2'd0) |-> room && (push.num != 2'd3))
		else $error("result queue overflow");

	a_ptr_track: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != '0) && (count_q != cls_pkg::QCNT_W'(cls_pkg::QDEPTH)) |->
		(wr_ptr_q != rd_ptr_q))
		else $error("result queue pointers disagree with count");

endmodule

`default_nettype wire
